@@ src/mah_pkg.sv @@
// ----------------------------------------------------------------------------
// mah_pkg
// Shared types, sizes and the arctangent table for the magnetometer window
// average and heading block.
// ----------------------------------------------------------------------------
package mah_pkg;

   // Window length of the sample ring (a power of two)
   localparam int RING_DEPTH   = 16;
   localparam int RING_AW      = $clog2(RING_DEPTH);
   localparam int CORDIC_STEPS = 16;
   localparam int STEP_W       = $clog2(CORDIC_STEPS);
   localparam int ATAN_IDX_W   = 5;

   // Assembled axis widths
   localparam int XY_W = 13;
   localparam int Z_W  = 15;
   localparam int RING_W = 2 * XY_W + Z_W;

   // Running sums grow by log2 of the window
   localparam int XS_W = XY_W + RING_AW;
   localparam int ZS_W = Z_W + RING_AW;

   // Result widths
   localparam int XA_W = 17;
   localparam int ZA_W = 19;
   localparam int HD_W = 15;

   // CORDIC datapath widths: vector in Q8 of the average, angle in Q30
   localparam int CV_W = 28;
   localparam int CA_W = 34;

   localparam logic signed [CA_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
   localparam logic signed [CA_W-1:0] ROUND_BIAS  = 34'sd131072;
   localparam logic signed [15:0]     HEAD_MAX    = 16'sd12868;
   localparam logic signed [15:0]     HEAD_MIN    = -16'sd12868;

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_REPORT = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SAMPLE,
      ST_PREP,
      ST_ITER,
      ST_DONE
   } state_type;

   // atan(2^-i) in radians times 2^30
   function automatic logic signed [CA_W-1:0] atan_q30(input logic [ATAN_IDX_W-1:0] idx);
      logic signed [CA_W-1:0] val;
      case (idx)
         5'd0:    val = 34'sd843314857;
         5'd1:    val = 34'sd497837829;
         5'd2:    val = 34'sd263043837;
         5'd3:    val = 34'sd133525159;
         5'd4:    val = 34'sd67021687;
         5'd5:    val = 34'sd33543516;
         5'd6:    val = 34'sd16775851;
         5'd7:    val = 34'sd8388437;
         5'd8:    val = 34'sd4194283;
         5'd9:    val = 34'sd2097149;
         5'd10:   val = 34'sd1048576;
         5'd11:   val = 34'sd524288;
         5'd12:   val = 34'sd262144;
         5'd13:   val = 34'sd131072;
         5'd14:   val = 34'sd65536;
         5'd15:   val = 34'sd32768;
         5'd16:   val = 34'sd16384;
         5'd17:   val = 34'sd8192;
         5'd18:   val = 34'sd4096;
         5'd19:   val = 34'sd2048;
         5'd20:   val = 34'sd1024;
         5'd21:   val = 34'sd512;
         5'd22:   val = 34'sd256;
         5'd23:   val = 34'sd128;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

@@ src/magnetometer_average_heading.sv @@
// ----------------------------------------------------------------------------
// magnetometer_average_heading
// Sliding window average of three magnetometer axes with a CORDIC heading.
// ----------------------------------------------------------------------------
// A sample transaction (op 0) assembles signed x, y (13 bit) and z (15 bit)
// from the raw register bytes, replaces the oldest entry of a 16-deep ring
// memory and updates running sums; it reads the memory, then writes back,
// and returns nothing. A report transaction (op 1) returns the three window
// averages (4 fractional bits) and atan2(y_avg, x_avg) in radians times
// 4096; it runs a prepare state, the CORDIC steps and a done state, the
// one shared CORDIC vectoring stage doing one step per cycle. One transaction
// is in work at a time; a finished result waits in the output register
// while the next transaction is taken. The ring reads as zero after reset.
// ----------------------------------------------------------------------------
module magnetometer_average_heading (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_op,
   input  logic [7:0]                        req_x_lsb,
   input  logic [7:0]                        req_x_msb,
   input  logic [7:0]                        req_y_lsb,
   input  logic [7:0]                        req_y_msb,
   input  logic [7:0]                        req_z_lsb,
   input  logic [7:0]                        req_z_msb,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [mah_pkg::XA_W-1:0]   rsp_x_avg,
   output logic signed [mah_pkg::XA_W-1:0]   rsp_y_avg,
   output logic signed [mah_pkg::ZA_W-1:0]   rsp_z_avg,
   output logic signed [mah_pkg::HD_W-1:0]   rsp_heading
);

   localparam int XY_W = mah_pkg::XY_W;
   localparam int Z_W  = mah_pkg::Z_W;
   localparam int XS_W = mah_pkg::XS_W;
   localparam int ZS_W = mah_pkg::ZS_W;
   localparam int AW   = mah_pkg::RING_AW;
   localparam int CV_W = mah_pkg::CV_W;
   localparam int CA_W = mah_pkg::CA_W;

   mah_pkg::state_type state_ff, state_in;

   // control outputs of the sequencer
   logic req_take;
   logic ring_we;
   logic prep_en;
   logic iter_en;
   logic done_en;

   logic in_accept;
   logic rsp_free;

   // ring memory and its fill flags
   logic [mah_pkg::RING_W-1:0] ring_mem [mah_pkg::RING_DEPTH];
   logic [mah_pkg::RING_W-1:0] ring_rd_ff;
   logic [mah_pkg::RING_DEPTH-1:0] fill_ff, fill_in;
   logic                       old_fill_ff;
   logic [AW-1:0]              slot_ff, slot_in;

   logic signed [XY_W-1:0] smp_x_ff, smp_y_ff;
   logic signed [Z_W-1:0]  smp_z_ff;
   logic signed [XY_W-1:0] old_x, old_y;
   logic signed [Z_W-1:0]  old_z;

   logic signed [XS_W-1:0] x_sum_ff, x_sum_in, y_sum_ff, y_sum_in;
   logic signed [ZS_W-1:0] z_sum_ff, z_sum_in;

   // averages
   logic signed [XS_W+5:0] x_num, y_num;
   logic signed [ZS_W+5:0] z_num;
   logic signed [XS_W+5:0] x_shr, y_shr;
   logic signed [ZS_W+5:0] z_shr;
   logic signed [mah_pkg::XA_W-1:0] x_avg, y_avg;
   logic signed [mah_pkg::ZA_W-1:0] z_avg;
   logic signed [mah_pkg::XA_W-1:0] x_avg_ff, y_avg_ff;
   logic signed [mah_pkg::ZA_W-1:0] z_avg_ff;

   // CORDIC
   logic signed [CV_W-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [CA_W-1:0] cz_ff, cz_in;
   logic signed [CV_W-1:0] px, py, dx, dy;
   logic [mah_pkg::STEP_W-1:0] step_ff, step_in;
   logic                   zero_ff, zero_in;
   logic signed [CA_W-1:0] z_round;
   logic signed [15:0]     head_full;
   logic signed [mah_pkg::HD_W-1:0] head_sat;

   logic rsp_valid_ff, rsp_valid_in;
   logic signed [mah_pkg::XA_W-1:0] rsp_x_ff, rsp_y_ff;
   logic signed [mah_pkg::ZA_W-1:0] rsp_z_ff;
   logic signed [mah_pkg::HD_W-1:0] rsp_h_ff;

   assign in_accept = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mah_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_op == mah_pkg::OP_REPORT) ? mah_pkg::ST_PREP
                                                         : mah_pkg::ST_SAMPLE;
            end
         end
         mah_pkg::ST_SAMPLE: state_in = mah_pkg::ST_IDLE;
         mah_pkg::ST_PREP:   state_in = mah_pkg::ST_ITER;
         mah_pkg::ST_ITER: begin
            if (step_ff == mah_pkg::STEP_W'(mah_pkg::CORDIC_STEPS - 1)) begin
               state_in = mah_pkg::ST_DONE;
            end
         end
         mah_pkg::ST_DONE: begin
            if (rsp_free) begin
               state_in = mah_pkg::ST_IDLE;
            end
         end
         default: state_in = mah_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_take = 1'b0;
      ring_we  = 1'b0;
      prep_en  = 1'b0;
      iter_en  = 1'b0;
      done_en  = 1'b0;
      case (state_ff)
         mah_pkg::ST_IDLE:   req_take = 1'b1;
         mah_pkg::ST_SAMPLE: ring_we  = 1'b1;
         mah_pkg::ST_PREP:   prep_en  = 1'b1;
         mah_pkg::ST_ITER:   iter_en  = 1'b1;
         mah_pkg::ST_DONE:   done_en  = rsp_free;
         default: ;
      endcase
   end

   assign req_stall = !req_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mah_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---------------------------------------------------------------- ring
   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[slot_ff] <= {smp_x_ff, smp_y_ff, smp_z_ff};
      end
      ring_rd_ff <= ring_mem[slot_ff];
   end

   // an entry never written counts as zero
   assign old_x = old_fill_ff ? ring_rd_ff[mah_pkg::RING_W-1 -: XY_W] : '0;
   assign old_y = old_fill_ff ? ring_rd_ff[Z_W+XY_W-1 -: XY_W] : '0;
   assign old_z = old_fill_ff ? ring_rd_ff[Z_W-1:0] : '0;

   always_comb begin
      fill_in  = fill_ff;
      slot_in  = slot_ff;
      x_sum_in = x_sum_ff;
      y_sum_in = y_sum_ff;
      z_sum_in = z_sum_ff;
      if (ring_we) begin
         fill_in[slot_ff] = 1'b1;
         slot_in = (slot_ff == AW'(mah_pkg::RING_DEPTH - 1)) ? '0 : slot_ff + 1'b1;
         x_sum_in = x_sum_ff + {{AW{smp_x_ff[XY_W-1]}}, smp_x_ff}
                             - {{AW{old_x[XY_W-1]}}, old_x};
         y_sum_in = y_sum_ff + {{AW{smp_y_ff[XY_W-1]}}, smp_y_ff}
                             - {{AW{old_y[XY_W-1]}}, old_y};
         z_sum_in = z_sum_ff + {{AW{smp_z_ff[Z_W-1]}}, smp_z_ff}
                             - {{AW{old_z[Z_W-1]}}, old_z};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         slot_ff  <= '0;
         x_sum_ff <= '0;
         y_sum_ff <= '0;
         z_sum_ff <= '0;
      end else begin
         fill_ff  <= fill_in;
         slot_ff  <= slot_in;
         x_sum_ff <= x_sum_in;
         y_sum_ff <= y_sum_in;
         z_sum_ff <= z_sum_in;
      end
   end

   // capture the sample and the fill flag of the slot being read
   always_ff @(posedge clock) begin
      if (in_accept) begin
         smp_x_ff    <= {req_x_msb, req_x_lsb[7:3]};
         smp_y_ff    <= {req_y_msb, req_y_lsb[7:3]};
         smp_z_ff    <= {req_z_msb, req_z_lsb[7:1]};
         old_fill_ff <= fill_ff[slot_ff];
      end
   end

   // ---------------------------------------------------------------- averages
   // round(sum * 16 / depth), ties upward
   always_comb begin
      x_num = {x_sum_ff[XS_W-1], x_sum_ff, 5'b0} + (XS_W+6)'(mah_pkg::RING_DEPTH);
      y_num = {y_sum_ff[XS_W-1], y_sum_ff, 5'b0} + (XS_W+6)'(mah_pkg::RING_DEPTH);
      z_num = {z_sum_ff[ZS_W-1], z_sum_ff, 5'b0} + (ZS_W+6)'(mah_pkg::RING_DEPTH);
      x_shr = x_num >>> (AW + 1);
      y_shr = y_num >>> (AW + 1);
      z_shr = z_num >>> (AW + 1);
      x_avg = x_shr[mah_pkg::XA_W-1:0];
      y_avg = y_shr[mah_pkg::XA_W-1:0];
      z_avg = z_shr[mah_pkg::ZA_W-1:0];
   end

   // ---------------------------------------------------------------- CORDIC
   assign px = {{(CV_W-mah_pkg::XA_W-8){x_avg[mah_pkg::XA_W-1]}}, x_avg, 8'b0};
   assign py = {{(CV_W-mah_pkg::XA_W-8){y_avg[mah_pkg::XA_W-1]}}, y_avg, 8'b0};
   assign dx = cy_ff >>> step_ff;
   assign dy = cx_ff >>> step_ff;

   always_comb begin
      cx_in   = cx_ff;
      cy_in   = cy_ff;
      cz_in   = cz_ff;
      step_in = step_ff;
      zero_in = zero_ff;
      if (prep_en) begin
         step_in = '0;
         zero_in = (x_avg == '0) && (y_avg == '0);
         cx_in   = px;
         cy_in   = py;
         cz_in   = '0;
         // pre-rotate left half-plane vectors by a quarter turn
         if (px[CV_W-1]) begin
            if (!py[CV_W-1]) begin
               cx_in = py;
               cy_in = -px;
               cz_in = mah_pkg::HALF_PI_Q30;
            end else begin
               cx_in = -py;
               cy_in = px;
               cz_in = -mah_pkg::HALF_PI_Q30;
            end
         end
      end else if (iter_en) begin
         step_in = step_ff + 1'b1;
         if (!cy_ff[CV_W-1]) begin
            cx_in = cx_ff + dx;
            cy_in = cy_ff - dy;
            cz_in = cz_ff + mah_pkg::atan_q30(mah_pkg::ATAN_IDX_W'(step_ff));
         end else begin
            cx_in = cx_ff - dx;
            cy_in = cy_ff + dy;
            cz_in = cz_ff - mah_pkg::atan_q30(mah_pkg::ATAN_IDX_W'(step_ff));
         end
      end
   end

   always_ff @(posedge clock) begin
      cx_ff   <= cx_in;
      cy_ff   <= cy_in;
      cz_ff   <= cz_in;
      zero_ff <= zero_in;
      if (prep_en) begin
         x_avg_ff <= x_avg;
         y_avg_ff <= y_avg;
         z_avg_ff <= z_avg;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else begin
         step_ff <= step_in;
      end
   end

   // round to 2^-12 rad and clamp
   always_comb begin
      z_round   = cz_ff + mah_pkg::ROUND_BIAS;
      head_full = z_round[CA_W-1:18];
      if (zero_ff) begin
         head_sat = '0;
      end else if (head_full > mah_pkg::HEAD_MAX) begin
         head_sat = mah_pkg::HEAD_MAX[mah_pkg::HD_W-1:0];
      end else if (head_full < mah_pkg::HEAD_MIN) begin
         head_sat = mah_pkg::HEAD_MIN[mah_pkg::HD_W-1:0];
      end else begin
         head_sat = head_full[mah_pkg::HD_W-1:0];
      end
   end

   // ---------------------------------------------------------------- output
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (done_en) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (done_en) begin
         rsp_x_ff <= x_avg_ff;
         rsp_y_ff <= y_avg_ff;
         rsp_z_ff <= z_avg_ff;
         rsp_h_ff <= head_sat;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_x_avg   = rsp_x_ff;
   assign rsp_y_avg   = rsp_y_ff;
   assign rsp_z_avg   = rsp_z_ff;
   assign rsp_heading = rsp_h_ff;

   // ---------------------------------------------------------------- checks
   a_sample_writes_back: assert property (@(posedge clock) disable iff (reset)
      (in_accept && req_op == mah_pkg::OP_SAMPLE) |=> ring_we)
      else $error("sample transaction not written back to the ring");

   a_slot_advances: assert property (@(posedge clock) disable iff (reset)
      ring_we |=> (slot_ff != $past(slot_ff)) && fill_ff[$past(slot_ff)])
      else $error("ring slot did not advance after a write");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == mah_pkg::ST_DONE))
      else $error("result raised outside of the done state");

   a_rsp_held_in_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mah_pkg::ST_DONE && !rsp_free) |=> state_ff == mah_pkg::ST_DONE)
      else $error("done state left while the result register was occupied");

endmodule
